// ===== rtl/cfpd_pkg.sv =====
// Package for the CRC-16 framed packet decoder.
// Holds frame codes, parser phase codes, the result type and the CRC step.
// No dependencies.
`default_nettype none

package cfpd_pkg;

  localparam logic [7:0] SYNC_BYTE       = 8'h5A;
  localparam logic [7:0] TYPE_DATA       = 8'hA5;
  localparam logic [7:0] TYPE_PING       = 8'hA6;
  localparam logic [7:0] TYPE_PING_REPLY = 8'hA7;

  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam int unsigned PING_REPLY_LEN = 8;

  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TYPE   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEN_LO = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LEN_HI = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CRC_LO = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CRC_HI = 3'd5;
  localparam logic [PHASE_W-1:0] PH_BODY   = 3'd6;

  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_PING       = 2'd1;
  localparam logic [1:0] KIND_PING_REPLY = 2'd2;

  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_OK       = 2'd1;
  localparam logic [1:0] ST_BAD_CRC  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [1:0] frame_kind;
    logic       frame_end;
    logic [1:0] frame_status;
  } result_t;

  // CRC-16, MSB first, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_HDR_INIT = crc16_byte(crc16_byte(16'h0000, SYNC_BYTE), TYPE_DATA);

endpackage

`default_nettype wire

// ===== rtl/cfpd_in_if.sv =====
// Input channel of the framed packet decoder: one received serial byte per transaction.
// No dependencies.
`default_nettype none

interface cfpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfpd_out_if.sv =====
// Result channel of the framed packet decoder: one payload or ping result per transaction.
// No dependencies.
`default_nettype none

interface cfpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic [1:0] frame_kind;
  logic       frame_end;
  logic [1:0] frame_status;

  modport source (output valid, output payload_byte, output byte_index, output frame_kind,
                  output frame_end, output frame_status, input ready);
  modport sink (input valid, input payload_byte, input byte_index, input frame_kind,
                input frame_end, input frame_status, output ready);
endinterface

`default_nettype wire

// ===== rtl/crc16_framed_packet_decoder_unit.sv =====
// Throughput: one byte per cycle while out_res is not stalled.
// Input register, then parser step and CRC-16 byte update into the result register.
// Reset (rst_n low, synchronous): parser hunts sync, counters, CRC and valids cleared.
// Depends on cfpd_pkg, cfpd_in_if and cfpd_out_if.
`default_nettype none

module crc16_framed_packet_decoder_unit #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cfpd_in_if.sink     in_rx,
  cfpd_out_if.source  out_res
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

  logic                        s1_valid_r;
  logic [7:0]                  s1_byte_r;
  logic                        s1_adv;
  logic                        s1_fire;

  logic [cfpd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                         is_data_r, is_data_nxt;
  logic [15:0]                  len_r, len_nxt;
  logic [15:0]                  rx_crc_r, rx_crc_nxt;
  logic [15:0]                  crc_r, crc_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             count_inc;
  logic [15:0]                  crc_step;

  logic                         emit;
  cfpd_pkg::result_t            res;
  logic                         out_valid_r;
  cfpd_pkg::result_t            out_r;

  assign s1_adv      = !out_valid_r || out_res.ready || !emit;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_rx.ready = !s1_valid_r || s1_adv;

  assign count_inc = count_r + CNT_W'(1);
  assign crc_step  = cfpd_pkg::crc16_byte(crc_r, s1_byte_r);

  always_comb begin
    phase_nxt   = phase_r;
    is_data_nxt = is_data_r;
    len_nxt     = len_r;
    rx_crc_nxt  = rx_crc_r;
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    emit        = 1'b0;
    res         = '0;
    unique case (phase_r)
      cfpd_pkg::PH_TYPE: begin
        is_data_nxt = (s1_byte_r == cfpd_pkg::TYPE_DATA);
        if (s1_byte_r == cfpd_pkg::TYPE_DATA) begin
          crc_nxt   = cfpd_pkg::CRC_HDR_INIT;
          phase_nxt = cfpd_pkg::PH_LEN_LO;
        end else if (s1_byte_r == cfpd_pkg::TYPE_PING) begin
          phase_nxt        = cfpd_pkg::PH_IDLE;
          emit             = 1'b1;
          res.frame_kind   = cfpd_pkg::KIND_PING;
          res.frame_end    = 1'b1;
          res.frame_status = cfpd_pkg::ST_OK;
        end else if (s1_byte_r == cfpd_pkg::TYPE_PING_REPLY) begin
          count_nxt = '0;
          phase_nxt = cfpd_pkg::PH_BODY;
        end
      end
      cfpd_pkg::PH_LEN_LO: begin
        len_nxt[7:0] = s1_byte_r;
        crc_nxt      = crc_step;
        phase_nxt    = cfpd_pkg::PH_LEN_HI;
      end
      cfpd_pkg::PH_LEN_HI: begin
        len_nxt[15:8] = s1_byte_r;
        crc_nxt       = crc_step;
        phase_nxt     = cfpd_pkg::PH_CRC_LO;
      end
      cfpd_pkg::PH_CRC_LO: begin
        rx_crc_nxt[7:0] = s1_byte_r;
        phase_nxt       = cfpd_pkg::PH_CRC_HI;
      end
      cfpd_pkg::PH_CRC_HI: begin
        rx_crc_nxt[15:8] = s1_byte_r;
        count_nxt        = '0;
        phase_nxt        = cfpd_pkg::PH_BODY;
      end
      cfpd_pkg::PH_BODY: begin
        emit             = 1'b1;
        count_nxt        = count_inc;
        res.payload_byte = s1_byte_r;
        res.byte_index   = 8'(count_r);
        res.frame_kind   = is_data_r ? cfpd_pkg::KIND_DATA : cfpd_pkg::KIND_PING_REPLY;
        res.frame_status = cfpd_pkg::ST_BUSY;
        if (is_data_r) begin
          crc_nxt = crc_step;
        end
        if (!is_data_r && (count_inc >= CNT_W'(cfpd_pkg::PING_REPLY_LEN))) begin
          res.frame_end    = 1'b1;
          res.frame_status = cfpd_pkg::ST_OK;
        end
        if (count_inc >= CNT_W'(MAX_PAYLOAD)) begin
          res.frame_end    = 1'b1;
          res.frame_status = cfpd_pkg::ST_OVERFLOW;
        end else if (is_data_r && (16'(count_inc) >= len_r)) begin
          res.frame_end    = 1'b1;
          res.frame_status = (crc_step == rx_crc_r) ? cfpd_pkg::ST_OK : cfpd_pkg::ST_BAD_CRC;
        end
        if (res.frame_end) begin
          phase_nxt = cfpd_pkg::PH_IDLE;
          count_nxt = '0;
        end
      end
      default: begin
        phase_nxt = (s1_byte_r == cfpd_pkg::SYNC_BYTE) ? cfpd_pkg::PH_TYPE : cfpd_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= cfpd_pkg::PH_IDLE;
      is_data_r   <= 1'b0;
      len_r       <= '0;
      rx_crc_r    <= '0;
      crc_r       <= '0;
      count_r     <= '0;
    end else begin
      if (in_rx.ready) begin
        s1_valid_r <= in_rx.valid;
      end
      if (s1_fire) begin
        phase_r   <= phase_nxt;
        is_data_r <= is_data_nxt;
        len_r     <= len_nxt;
        rx_crc_r  <= rx_crc_nxt;
        crc_r     <= crc_nxt;
        count_r   <= count_nxt;
      end
      if (s1_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rx.ready && in_rx.valid) begin
      s1_byte_r <= in_rx.rx_byte;
    end
    if (s1_fire && emit) begin
      out_r <= res;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.payload_byte = out_r.payload_byte;
  assign out_res.byte_index   = out_r.byte_index;
  assign out_res.frame_kind   = out_r.frame_kind;
  assign out_res.frame_end    = out_r.frame_end;
  assign out_res.frame_status = out_r.frame_status;

`ifndef SYNTHESIS
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.frame_end) |-> (out_r.frame_status == cfpd_pkg::ST_BUSY))
    else $error("status set on a result that does not end a frame");

  a_ping_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.frame_kind == cfpd_pkg::KIND_PING)) |->
    (out_r.frame_end && (out_r.frame_status == cfpd_pkg::ST_OK) && (out_r.byte_index == 8'd0)))
    else $error("malformed ping result");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && emit && res.frame_end) |=> (phase_r == cfpd_pkg::PH_IDLE && count_r == '0))
    else $error("parser did not return to sync hunt after frame end");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(MAX_PAYLOAD))
    else $error("byte count reached capacity without abort");
`endif

endmodule

`default_nettype wire
